@@ rtl/core/ipes_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ipes_pkg
// Shared types and constants of the inverse perspective edge slope unit.
// ---------------------------------------------------------------------------
package ipes_pkg;

  // register indexes on the configuration port
  typedef enum logic [2:0] {
    REG_A1 = 3'd0,
    REG_A2 = 3'd1,
    REG_A3 = 3'd2,
    REG_B1 = 3'd3,
    REG_B2 = 3'd4,
    REG_B3 = 3'd5,
    REG_C1 = 3'd6,
    REG_C2 = 3'd7
  } cfg_reg_e;

  localparam logic signed [31:0] RstA1 = 32'sd479341;
  localparam logic signed [31:0] RstA2 = 32'sd0;
  localparam logic signed [31:0] RstA3 = 32'sd0;
  localparam logic signed [31:0] RstB1 = -32'sd840360;
  localparam logic signed [31:0] RstB2 = 32'sd347530;
  localparam logic signed [31:0] RstB3 = -32'sd8987;
  localparam logic signed [31:0] RstC1 = 32'sd53222722;
  localparam logic signed [31:0] RstC2 = 32'sd5153002;

  localparam int unsigned NumW  = 43;   // numerator / denominator sums
  localparam int unsigned DivW  = 52;   // ground divider compare width
  localparam int unsigned SdW   = 19;   // slope divider compare width

  localparam logic [42:0] OneQ20       = 43'd1048576;
  localparam logic [14:0] SlopeScale   = 15'd125;
  localparam logic [9:0]  LeftWheelX   = 10'd92;
  localparam logic [9:0]  RightWheelX  = 10'd97;
  localparam logic [8:0]  WheelYOffset = 9'd31;
  localparam logic [7:0]  GroundMax    = 8'd255;

  // per-item sideband carried down the pipeline
  typedef struct packed {
    logic [7:0] row;
    logic       in_map;
    logic [7:0] left_col;
    logic [7:0] right_col;
    logic [7:0] left_gx;
    logic [7:0] ground_y;
    logic [7:0] right_gx;
  } item_t;

endpackage

@@ rtl/core/inverse_perspective_edge_slope_unit.sv @@
`timescale 1ns / 1ps
// throughput: one edge pair per cycle while the output takes results; the
//   ground and slope dividers resolve one quotient bit per pipeline stage
// a stall on the output holds the whole pipeline in place
// reset clears all valid bits and loads the default homography coefficients
// ---------------------------------------------------------------------------
// inverse_perspective_edge_slope_unit
// Maps left/right edge points of an image row to ground coordinates and
// gives the scaled inverse slope of each point towards its wheel point.
// ---------------------------------------------------------------------------
module inverse_perspective_edge_slope_unit #(
  parameter int IMAGE_WIDTH = 188,
  parameter int MAP_ROWS    = 80
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [2:0]             cfg_idx_i,
  input  logic [31:0]            cfg_wdata_i,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // row, left_col, right_col
  input  logic [39:0]            s_axis_tdata,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // row_out, left_clamped, right_clamped, left_ground_x, left_ground_y,
  // right_ground_x, right_ground_y, left_slope, right_slope
  output logic [87:0]            m_axis_tdata
);
  import ipes_pkg::*;

  localparam int NumSt = 25;
  localparam logic [7:0] ColMax   = 8'(IMAGE_WIDTH - 1);
  localparam logic [8:0] RowLimit = 9'(MAP_ROWS);

  // stage map
  localparam int StIn  = 0;
  localparam int StMul = 1;
  localparam int StSum = 2;
  localparam int StAbs = 3;
  localparam int StGd0 = 4;   // overflow check, then 8 quotient bits
  localparam int StSd0 = 13;  // ground select, then 10 quotient bits
  localparam int StOut = 24;

  logic signed [31:0] a1_q, a2_q, a3_q, b1_q, b2_q, b3_q, c1_q, c2_q;

  logic [NumSt-1:0] vld_q;
  item_t            meta_q [NumSt];
  item_t            in_item;
  item_t            sd_item;
  logic             en;

  assign en            = !vld_q[StOut] || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld_q[StOut];

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a1_q <= RstA1; a2_q <= RstA2; a3_q <= RstA3; b1_q <= RstB1;
      b2_q <= RstB2; b3_q <= RstB3; c1_q <= RstC1; c2_q <= RstC2;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_A1:  a1_q <= cfg_wdata_i;
        REG_A2:  a2_q <= cfg_wdata_i;
        REG_A3:  a3_q <= cfg_wdata_i;
        REG_B1:  b1_q <= cfg_wdata_i;
        REG_B2:  b2_q <= cfg_wdata_i;
        REG_B3:  b3_q <= cfg_wdata_i;
        REG_C1:  c1_q <= cfg_wdata_i;
        REG_C2:  c2_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // input clamp
  logic signed [15:0] in_lcol, in_rcol;
  logic [7:0]         in_row, lcl, rcl;
  assign in_row  = s_axis_tdata[7:0];
  assign in_lcol = s_axis_tdata[23:8];
  assign in_rcol = s_axis_tdata[39:24];

  always_comb begin
    if (in_lcol < 0) lcl = 8'd0;
    else if (in_lcol > $signed({8'd0, ColMax})) lcl = ColMax;
    else lcl = in_lcol[7:0];
    if (in_rcol < 0) rcl = 8'd0;
    else if (in_rcol > $signed({8'd0, ColMax})) rcl = ColMax;
    else rcl = in_rcol[7:0];
  end

  always_comb begin
    in_item           = '0;
    in_item.row       = in_row;
    in_item.in_map    = {1'b0, in_row} < RowLimit;
    in_item.left_col  = lcl;
    in_item.right_col = rcl;
  end

  // products: lanes 0 left, 1 right
  logic signed [40:0] pa1_q [2];
  logic signed [40:0] pa3_q [2];
  logic signed [40:0] pb1_q, pb2_q, pb3_q;
  logic signed [31:0] c1_d1_q, c2_d1_q;
  // sums: lanes 0 left x, 1 right x, 2 y
  logic signed [NumW-1:0] num_q [3];
  logic signed [NumW-1:0] den_q [3];
  // magnitudes and special cases
  logic [NumW-1:0] anum_q [3];
  logic [NumW-1:0] aden_q [3];
  logic            zro_q  [3];
  logic            max_q  [3];
  // ground divider
  logic [DivW-1:0] gd_rem_q [3][9];
  logic [DivW-1:0] gd_den_q [3][9];
  logic [7:0]      gd_quo_q [3][9];
  logic            gd_zro_q [3][9];
  logic            gd_max_q [3][9];
  logic [DivW-1:0] gd_shf   [3][9];
  logic            gd_ge    [3][9];
  // slope divider: lanes 0 left, 1 right
  logic [SdW-1:0]  sd_rem_q [2][11];
  logic [SdW-1:0]  sd_den_q [2][11];
  logic [9:0]      sd_quo_q [2][11];
  logic            sd_neg_q [2][11];
  logic [SdW-1:0]  sd_shf   [2][11];
  logic            sd_ge    [2][11];
  logic signed [15:0] slope_q [2];

  // compare against shifted divisor for each quotient bit
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      gd_shf[l][0] = gd_den_q[l][0];
      gd_ge[l][0]  = 1'b0;
      for (int j = 1; j < 9; j++) begin
        gd_shf[l][j] = gd_den_q[l][j-1] << (8 - j);
        gd_ge[l][j]  = gd_rem_q[l][j-1] >= gd_shf[l][j];
      end
    end
    for (int l = 0; l < 2; l++) begin
      sd_shf[l][0] = sd_den_q[l][0];
      sd_ge[l][0]  = 1'b0;
      for (int j = 1; j < 11; j++) begin
        sd_shf[l][j] = sd_den_q[l][j-1] << (10 - j);
        sd_ge[l][j]  = sd_rem_q[l][j-1] >= sd_shf[l][j];
      end
    end
  end

  // ground values after the divider
  logic [7:0] gnd [3];
  logic signed [9:0] dx [2];
  logic [8:0] dmag [2];
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      if (!meta_q[StSd0-1].in_map || gd_zro_q[l][8]) gnd[l] = 8'd0;
      else if (gd_max_q[l][8]) gnd[l] = GroundMax;
      else gnd[l] = gd_quo_q[l][8];
    end
    dx[0] = $signed({2'b00, gnd[0]}) - $signed(LeftWheelX);
    dx[1] = $signed({2'b00, gnd[1]}) - $signed(RightWheelX);
    for (int l = 0; l < 2; l++) begin
      dmag[l] = dx[l][9] ? 9'(-dx[l]) : dx[l][8:0];
    end
    sd_item          = meta_q[StSd0-1];
    sd_item.left_gx  = gnd[0];
    sd_item.right_gx = gnd[1];
    sd_item.ground_y = gnd[2];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NumSt-2:0], s_axis_tvalid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      // stage 0: clamp
      meta_q[StIn] <= in_item;
      // stage 13 picks up the ground values
      for (int s = 1; s < NumSt; s++) begin
        if (s == StSd0) meta_q[s] <= sd_item;
        else meta_q[s] <= meta_q[s-1];
      end

      // stage 1: products
      pa1_q[0] <= a1_q * $signed({1'b0, meta_q[StIn].left_col});
      pa1_q[1] <= a1_q * $signed({1'b0, meta_q[StIn].right_col});
      pa3_q[0] <= a3_q * $signed({1'b0, meta_q[StIn].left_col});
      pa3_q[1] <= a3_q * $signed({1'b0, meta_q[StIn].right_col});
      pb1_q    <= b1_q * $signed({1'b0, meta_q[StIn].row});
      pb2_q    <= b2_q * $signed({1'b0, meta_q[StIn].row});
      pb3_q    <= b3_q * $signed({1'b0, meta_q[StIn].row});
      c1_d1_q  <= c1_q;
      c2_d1_q  <= c2_q;

      // stage 2: sums
      for (int l = 0; l < 2; l++) begin
        num_q[l] <= NumW'(pa1_q[l]) + NumW'(pb1_q) + NumW'(c1_d1_q);
        den_q[l] <= NumW'(pa3_q[l]) + NumW'(pb3_q) + $signed(OneQ20);
      end
      num_q[2] <= NumW'(pb2_q) + NumW'(c2_d1_q);
      den_q[2] <= NumW'(pb3_q) + $signed(OneQ20);

      // stage 3: signs and magnitudes
      for (int l = 0; l < 3; l++) begin
        anum_q[l] <= num_q[l][NumW-1] ? NumW'(-num_q[l]) : NumW'(num_q[l]);
        aden_q[l] <= den_q[l][NumW-1] ? NumW'(-den_q[l]) : NumW'(den_q[l]);
        if (den_q[l] == '0) begin
          max_q[l] <= (num_q[l] > 0);
          zro_q[l] <= !(num_q[l] > 0);
        end else begin
          max_q[l] <= 1'b0;
          zro_q[l] <= num_q[l][NumW-1] != den_q[l][NumW-1];
        end
      end

      // stage 4: quotient of 256 or more saturates
      for (int l = 0; l < 3; l++) begin
        gd_rem_q[l][0] <= DivW'(anum_q[l]);
        gd_den_q[l][0] <= DivW'(aden_q[l]);
        gd_quo_q[l][0] <= '0;
        gd_zro_q[l][0] <= zro_q[l];
        gd_max_q[l][0] <= max_q[l] ||
                          (!zro_q[l] && (DivW'(anum_q[l]) >= (DivW'(aden_q[l]) << 8)));
        // stages 5..12: one quotient bit each
        for (int j = 1; j < 9; j++) begin
          gd_den_q[l][j] <= gd_den_q[l][j-1];
          gd_zro_q[l][j] <= gd_zro_q[l][j-1];
          gd_max_q[l][j] <= gd_max_q[l][j-1];
          gd_rem_q[l][j] <= gd_ge[l][j] ? gd_rem_q[l][j-1] - gd_shf[l][j]
                                        : gd_rem_q[l][j-1];
          gd_quo_q[l][j] <= gd_quo_q[l][j-1] | ({7'd0, gd_ge[l][j]} << (8 - j));
        end
      end

      // stage 13: slope numerator and divisor
      for (int l = 0; l < 2; l++) begin
        sd_rem_q[l][0] <= SdW'(15'(dmag[l]) * SlopeScale);
        sd_den_q[l][0] <= SdW'({1'b0, gnd[2]} + WheelYOffset);
        sd_quo_q[l][0] <= '0;
        sd_neg_q[l][0] <= dx[l][9];
        // stages 14..23: one quotient bit each
        for (int j = 1; j < 11; j++) begin
          sd_den_q[l][j] <= sd_den_q[l][j-1];
          sd_neg_q[l][j] <= sd_neg_q[l][j-1];
          sd_rem_q[l][j] <= sd_ge[l][j] ? sd_rem_q[l][j-1] - sd_shf[l][j]
                                        : sd_rem_q[l][j-1];
          sd_quo_q[l][j] <= sd_quo_q[l][j-1] | ({9'd0, sd_ge[l][j]} << (10 - j));
        end
        // stage 24: apply sign
        slope_q[l] <= sd_neg_q[l][10] ? -$signed({6'd0, sd_quo_q[l][10]})
                                      : $signed({6'd0, sd_quo_q[l][10]});
      end
    end
  end

  assign m_axis_tdata = {slope_q[1], slope_q[0],
                         meta_q[StOut].ground_y, meta_q[StOut].right_gx,
                         meta_q[StOut].ground_y, meta_q[StOut].left_gx,
                         meta_q[StOut].right_col, meta_q[StOut].left_col,
                         meta_q[StOut].row};

endmodule
